@@ rtl/wzc_pkg.sv @@
// ----------------------------------------------------------------------------
// wzc_pkg
// Shared types and constants for the windowed zero crossing counter.
// ----------------------------------------------------------------------------
package wzc_pkg;

   localparam int WINDOW_MAX_DEFAULT = 1024;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRIGGER_LEVEL = 2'd0,
      CSR_DC_OFFSET     = 2'd1,
      CSR_WINDOW_LENGTH = 2'd2
   } csr_index_type;

   localparam logic [14:0]        TRIGGER_LEVEL_RESET = 15'd2000;
   localparam logic signed [15:0] DC_OFFSET_RESET     = 16'sd0;
   localparam logic [10:0]        WINDOW_LENGTH_RESET = 11'd1024;

   typedef struct packed {
      logic [14:0]        trigger_level;
      logic signed [15:0] dc_offset;
      logic               window_clear;
   } cfg_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic mark;
   } mark_ctl_type;

endpackage

@@ rtl/wzc_csr.sv @@
// ----------------------------------------------------------------------------
// wzc_csr
// Configuration registers and effective window length.
// ----------------------------------------------------------------------------
module wzc_csr #(
   parameter int WINDOW_MAX = wzc_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [wzc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wzc_pkg::CSR_DATA_W-1:0]       csr_write_data,
   output wzc_pkg::cfg_type                     cfg,
   output logic [$clog2(WINDOW_MAX+1)-1:0]      eff_len
);
   import wzc_pkg::*;

   localparam int LW = $clog2(WINDOW_MAX + 1);

   logic [14:0]        trigger_level_ff, trigger_level_in;
   logic signed [15:0] dc_offset_ff, dc_offset_in;
   logic [10:0]        window_length_ff, window_length_in;
   logic               window_clear;

   always_comb begin
      trigger_level_in = trigger_level_ff;
      dc_offset_in     = dc_offset_ff;
      window_length_in = window_length_ff;
      window_clear     = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_TRIGGER_LEVEL: begin
               trigger_level_in = csr_write_data[14:0];
            end
            CSR_DC_OFFSET: begin
               dc_offset_in = csr_write_data;
            end
            CSR_WINDOW_LENGTH: begin
               window_length_in = csr_write_data[10:0];
               window_clear     = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_level_ff <= TRIGGER_LEVEL_RESET;
         dc_offset_ff     <= DC_OFFSET_RESET;
         window_length_ff <= WINDOW_LENGTH_RESET;
      end else begin
         trigger_level_ff <= trigger_level_in;
         dc_offset_ff     <= dc_offset_in;
         window_length_ff <= window_length_in;
      end
   end

   // zero means one, clamp at the store depth
   always_comb begin
      if (window_length_ff == '0) begin
         eff_len = LW'(1);
      end else if (32'(window_length_ff) > 32'(WINDOW_MAX)) begin
         eff_len = LW'(WINDOW_MAX);
      end else begin
         eff_len = LW'(window_length_ff);
      end
   end

   assign cfg.trigger_level = trigger_level_ff;
   assign cfg.dc_offset     = dc_offset_ff;
   assign cfg.window_clear  = window_clear;

endmodule

@@ rtl/wzc_mark_store.sv @@
// ----------------------------------------------------------------------------
// wzc_mark_store
// Circular crossing mark memory with write position and prefetched read.
// ----------------------------------------------------------------------------
module wzc_mark_store #(
   parameter int WINDOW_MAX = wzc_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  wzc_pkg::mark_ctl_type             ctl,
   input  logic [$clog2(WINDOW_MAX+1)-1:0]   eff_len,
   output logic                              retired_mark
);
   import wzc_pkg::*;

   localparam int AW = $clog2(WINDOW_MAX);
   localparam int LW = $clog2(WINDOW_MAX + 1);

   logic          mem [WINDOW_MAX];
   logic [AW-1:0] pos_ff, pos_in;
   logic          wrapped_ff, wrapped_in;
   logic          rd_ff;
   logic [LW-1:0] pos_inc;
   logic          wrap;
   logic [AW-1:0] pos_next;
   logic [AW-1:0] rd_addr;

   assign pos_inc  = LW'(pos_ff) + LW'(1);
   assign wrap     = (pos_inc >= eff_len);
   assign pos_next = wrap ? '0 : pos_inc[AW-1:0];
   assign rd_addr  = ctl.step ? pos_next : pos_ff;

   // entries are only trusted once the position has gone all the way round
   always_comb begin
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      if (ctl.clear) begin
         pos_in     = '0;
         wrapped_in = 1'b0;
      end else if (ctl.step) begin
         pos_in     = pos_next;
         wrapped_in = wrapped_ff | wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         wrapped_ff <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         mem[pos_ff] <= ctl.mark;
      end
      if (ctl.step && (pos_next == pos_ff)) begin
         rd_ff <= ctl.mark;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign retired_mark = rd_ff & wrapped_ff;

endmodule

@@ rtl/windowed_zero_cross_counter_core.sv @@
// Each rsp transaction appears in the cycle after its req is accepted.
// Throughput: one transaction per cycle unless a stalled rsp holds req_stall;
// the mark memory takes one read plus one write per cycle.
// Reset: synchronous; clears counts, polarity, arming, peak and window state,
// with no clearing pass over the mark memory.
// ----------------------------------------------------------------------------
// windowed_zero_cross_counter_core
// Zero crossing count over a sliding window with hysteresis, plus peak level.
// ----------------------------------------------------------------------------
module windowed_zero_cross_counter_core #(
   parameter int WINDOW_MAX = wzc_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [wzc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wzc_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [15:0]               req_sample,
   input  logic                             req_block_start,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [10:0]                      rsp_crossing_count,
   output logic [15:0]                      rsp_peak_level
);
   import wzc_pkg::*;

   localparam int LW = $clog2(WINDOW_MAX + 1);

   cfg_type       cfg;
   logic [LW-1:0] eff_len;
   mark_ctl_type  mark_ctl;
   logic          retired_mark;

   logic          req_accept;
   logic          rsp_accept;
   logic [15:0]   corrected;
   logic          negative;
   logic          positive;
   logic [15:0]   magnitude;
   logic          crossing;

   logic          polarity_neg_ff, polarity_neg_in;
   logic          armed_ff, armed_in;
   logic [15:0]   peak_ff, peak_in;
   logic [LW-1:0] total_ff, total_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [10:0]   rsp_count_ff;
   logic [15:0]   rsp_peak_ff;

   wzc_csr #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .eff_len          (eff_len)
   );

   wzc_mark_store #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_mark_store (
      .clock        (clock),
      .reset        (reset),
      .ctl          (mark_ctl),
      .eff_len      (eff_len),
      .retired_mark (retired_mark)
   );

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_accept = rsp_valid_ff & ~rsp_stall;

   assign corrected = req_sample + cfg.dc_offset;
   assign negative  = corrected[15];
   assign positive  = ~negative & (corrected != '0);
   assign magnitude = negative ? (~corrected + 16'd1) : corrected;
   assign crossing  = armed_ff & ((~polarity_neg_ff & negative) | (polarity_neg_ff & positive));

   assign mark_ctl.clear = cfg.window_clear;
   assign mark_ctl.step  = req_accept;
   assign mark_ctl.mark  = crossing;

   always_comb begin
      polarity_neg_in = polarity_neg_ff;
      armed_in        = armed_ff;
      peak_in         = peak_ff;
      total_in        = total_ff;
      if (cfg.window_clear) begin
         total_in = '0;
      end else if (req_accept) begin
         total_in        = total_ff - LW'(retired_mark) + LW'(crossing);
         polarity_neg_in = polarity_neg_ff ^ crossing;
         armed_in        = (armed_ff & ~crossing) | (magnitude > {1'b0, cfg.trigger_level});
         if (req_block_start || (magnitude > peak_ff)) begin
            peak_in = magnitude;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_neg_ff <= 1'b0;
         armed_ff        <= 1'b0;
         peak_ff         <= '0;
         total_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         polarity_neg_ff <= polarity_neg_in;
         armed_ff        <= armed_in;
         peak_ff         <= peak_in;
         total_ff        <= total_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_count_ff <= 11'(total_in);
         rsp_peak_ff  <= peak_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_crossing_count = rsp_count_ff;
   assign rsp_peak_level     = rsp_peak_ff;

endmodule

@@ sim/windowed_zero_cross_counter_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_zero_cross_counter_core_tb
// Self-checking bench for the windowed zero crossing counter. Samples stream
// in through a queue-fed driver, a clocked monitor predicts each response from
// a local copy of the window state and compares it field by field. Register
// settings change between idle phases; both sides stall at random.
// ----------------------------------------------------------------------------
module windowed_zero_cross_counter_core_tb;
   import wzc_pkg::*;

   localparam int WINDOW_MAX = WINDOW_MAX_DEFAULT;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_UNUSED = 2'd3;
   localparam int SEGMENTS = 6;
   localparam int SEGMENT_ITEMS = 84;

   typedef struct packed {
      logic [15:0] pcm;
      logic        block_start;
   } pcm_item_type;

   typedef struct packed {
      logic [10:0] crossing_count;
      logic [15:0] peak_level;
   } zc_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [15:0]     req_sample = '0;
   logic                   req_block_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [10:0]            rsp_crossing_count;
   logic [15:0]            rsp_peak_level;

   windowed_zero_cross_counter_core #(
      .WINDOW_MAX(WINDOW_MAX)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_block_start    (req_block_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_crossing_count (rsp_crossing_count),
      .rsp_peak_level     (rsp_peak_level)
   );

   // predictor copy of registers and window state
   logic [14:0] trig_level = TRIGGER_LEVEL_RESET;
   logic [15:0] dc_off     = DC_OFFSET_RESET;
   logic [10:0] win_len    = WINDOW_LENGTH_RESET;
   bit          marks[WINDOW_MAX];
   int unsigned cross_total = 0;
   bit          was_negative = 1'b0;
   bit          is_armed = 1'b0;
   int unsigned wr_pos = 0;
   logic [16:0] peak_hold = '0;

   pcm_item_type  sample_queue[$];
   zc_result_type expected_counts[$];
   int unsigned issued_count = 0;
   int unsigned accepted_count = 0;
   int unsigned error_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic        req_fire = 1'b0;
   bit          wave_negative = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("windowed_zero_cross_counter_core verification failed");
      $finish;
   end

   function automatic void clear_window_marks();
      foreach (marks[i]) marks[i] = 1'b0;
      cross_total = 0;
      wr_pos = 0;
   endfunction

   function automatic zc_result_type update_crossing_window(logic [15:0] pcm, logic blk);
      int unsigned   len;
      logic [15:0]   corr;
      logic          neg, pos;
      logic [16:0]   mag;
      zc_result_type res;
      len = (win_len == 0) ? 1 : ((win_len > WINDOW_MAX) ? WINDOW_MAX : win_len);
      if (wr_pos >= len) wr_pos = 0;
      if (marks[wr_pos] && cross_total > 0) cross_total--;
      marks[wr_pos] = 1'b0;
      corr = pcm + dc_off;
      neg = corr[15];
      pos = !neg && (corr != 16'd0);
      mag = neg ? (17'h10000 - {1'b0, corr}) : {1'b0, corr};
      if (is_armed) begin
         if ((!was_negative && neg) || (was_negative && pos)) begin
            cross_total++;
            marks[wr_pos] = 1'b1;
            is_armed = 1'b0;
            was_negative = neg;
         end
      end
      if (mag > {2'b00, trig_level}) is_armed = 1'b1;
      if (blk || mag > peak_hold) peak_hold = mag;
      wr_pos++;
      if (wr_pos >= len) wr_pos = 0;
      res.crossing_count = cross_total[10:0];
      res.peak_level = peak_hold[15:0];
      return res;
   endfunction

   // driver: payload changes only after the previous transaction was taken
   always @(negedge clock) begin : drive_samples
      logic launch;
      if (!reset) begin
         if (req_fire) void'(sample_queue.pop_front());
         if (!req_valid || req_fire) begin
            launch = (sample_queue.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            req_valid <= launch;
            if (launch) begin
               req_sample <= sample_queue[0].pcm;
               req_block_start <= sample_queue[0].block_start;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   // monitor: checks responses, predicts each accepted request
   always @(posedge clock) begin : watch_ports
      zc_result_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               error_count++;
               $display("%0t: unexpected rsp transaction, count %0d peak %0d",
                        $time, rsp_crossing_count, rsp_peak_level);
            end else begin
               want = expected_counts.pop_front();
               if (rsp_crossing_count !== want.crossing_count) begin
                  error_count++;
                  $display("%0t: crossing_count expected %0d actual %0d",
                           $time, want.crossing_count, rsp_crossing_count);
               end
               if (rsp_peak_level !== want.peak_level) begin
                  error_count++;
                  $display("%0t: peak_level expected %0d actual %0d",
                           $time, want.peak_level, rsp_peak_level);
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_counts.push_back(update_crossing_window(req_sample, req_block_start));
            accepted_count++;
         end
      end
   end

   task automatic send(input logic [15:0] pcm, input logic blk);
      pcm_item_type item;
      item.pcm = pcm;
      item.block_start = blk;
      sample_queue.push_back(item);
      issued_count++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (accepted_count != issued_count || expected_counts.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_TRIGGER_LEVEL: trig_level = data[14:0];
         CSR_DC_OFFSET:     dc_off = data;
         CSR_WINDOW_LENGTH: begin
            win_len = data[10:0];
            clear_window_marks();
         end
         default: ;
      endcase
   endtask

   // mostly a toggling waveform around the trigger level, some raw noise
   function automatic logic [15:0] make_pcm();
      int unsigned pick, mag;
      logic [15:0] target;
      pick = $urandom_range(99);
      if (pick < 15) return 16'($urandom_range(16'hFFFF));
      if (pick < 25) begin
         case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'hFFFF;
         endcase
      end
      if ($urandom_range(2) == 0) wave_negative = !wave_negative;
      mag = $urandom_range(trig_level * 2 + 100);
      if (mag > 32768) mag = 32768;
      target = wave_negative ? 16'(17'h10000 - mag) : 16'(mag);
      return target - dc_off;
   endfunction

   task automatic pick_settings();
      logic [14:0] trig;
      logic [15:0] off;
      logic [10:0] len;
      case ($urandom_range(5))
         0: trig = 15'd0;
         1: trig = 15'h7FFF;
         2: trig = 15'($urandom_range(32767));
         default: trig = 15'($urandom_range(4000));
      endcase
      case ($urandom_range(5))
         0: off = 16'h0000;
         1: off = 16'h7FFF;
         2: off = 16'h8000;
         3: off = 16'($urandom_range(16'hFFFF));
         default: off = 16'($urandom_range(400)) - 16'd200;
      endcase
      case ($urandom_range(9))
         0: len = 11'd0;
         1: len = 11'd1;
         2: len = 11'd1024;
         3: len = 11'($urandom_range(2047, 1025));
         default: len = 11'($urandom_range(64, 2));
      endcase
      write_csr(CSR_TRIGGER_LEVEL, {1'($urandom_range(1)), trig});
      write_csr(CSR_DC_OFFSET, off);
      write_csr(CSR_WINDOW_LENGTH, {5'($urandom_range(31)), len});
      if ($urandom_range(3) == 0)
         write_csr(CSR_INDEX_UNUSED, 16'($urandom_range(16'hFFFF)));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: hysteresis, zero, extremes, block start
      @(posedge clock);
      send(16'h0000, 1'b1);
      send(16'h7FFF, 1'b0);
      send(16'h8000, 1'b0);
      send(16'h0001, 1'b0);
      send(16'hFFFF, 1'b0);
      send(16'd2001, 1'b0);
      send(16'h0000, 1'b0);
      send(-16'sd2000, 1'b0);
      send(16'd2000, 1'b1);
      wait_idle();

      // offset wrap in both directions
      write_csr(CSR_DC_OFFSET, 16'h7FFF);
      @(posedge clock);
      send(16'h0001, 1'b0);
      send(16'h7FFF, 1'b0);
      wait_idle();
      write_csr(CSR_DC_OFFSET, 16'h8000);
      @(posedge clock);
      send(16'hFFFF, 1'b0);
      send(16'h0000, 1'b1);
      wait_idle();

      // trigger extremes, then window write restarts the count
      write_csr(CSR_TRIGGER_LEVEL, 16'hFFFF);
      @(posedge clock);
      send(16'h0000, 1'b0);
      send(16'h7FFF, 1'b0);
      wait_idle();
      write_csr(CSR_TRIGGER_LEVEL, 16'h0000);
      write_csr(CSR_INDEX_UNUSED, 16'hFFFF);
      write_csr(CSR_WINDOW_LENGTH, 16'h0000);
      @(posedge clock);
      send(16'h8001, 1'b0);
      send(16'h0000, 1'b0);
      send(16'h8001, 1'b0);
      wait_idle();
      write_csr(CSR_WINDOW_LENGTH, 16'hFFFF);
      @(posedge clock);
      send(16'h0000, 1'b0);
      send(16'h8001, 1'b0);
      send(16'h0000, 1'b0);
      wait_idle();
      write_csr(CSR_WINDOW_LENGTH, 16'd2);
      @(posedge clock);
      send(16'h8001, 1'b0);
      send(16'h0000, 1'b0);
      send(16'h8001, 1'b0);
      wait_idle();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         pick_settings();
         @(posedge clock);
         if (seg < 2) begin
            send_idle_pct = 9;
            recv_idle_pct = 85;
         end else if (seg < 4) begin
            send_idle_pct = 85;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < SEGMENT_ITEMS / 2; n++)
            send(make_pcm(), $urandom_range(9) == 0);
         if (seg == 3) begin
            wait_idle();
            @(posedge clock);
         end
         for (int n = 0; n < SEGMENT_ITEMS / 2; n++)
            send(make_pcm(), $urandom_range(9) == 0);
         wait_idle();
      end

      repeat (4) @(negedge clock);
      if (expected_counts.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses never arrived", $time, expected_counts.size());
      end
      if (error_count == 0)
         $display("windowed_zero_cross_counter_core verification clean");
      else
         $display("windowed_zero_cross_counter_core verification failed");
      $finish;
   end

endmodule
